/* hdl/vt44_pkg.sv */
// Shared types, constants and arithmetic helpers of the 4x4 vertex transform unit.
package vt44_pkg;

  // Fixed-point format and data widths.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int VEC_N     = 4;
  localparam int NUM_COEFF = VEC_N * VEC_N;
  localparam int IDX_W     = $clog2(NUM_COEFF);
  localparam int PROD_W    = 2 * DATA_W;
  // A shifted product keeps PROD_W - FRAC_BITS bits; four of them need two more.
  localparam int SUM_W     = PROD_W - FRAC_BITS + 2;

  // One in the fixed-point format, and the clipping bounds.
  localparam logic [DATA_W-1:0] FX_ONE  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Queue geometry, shared by the job queue and the result buffer.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Item operation codes.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    op_t                           op;
    logic                          affine;
    logic [IDX_W-1:0]              index;
    logic [DATA_W-1:0]             value;
    logic [VEC_N-1:0][DATA_W-1:0]  vec;
  } job_t;

  // One result item.
  typedef struct packed {
    logic [VEC_N-1:0][DATA_W-1:0]  comp;
    logic                          saturated;
  } result_t;

  // Status of the job queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Exact signed product of two fixed-point values.
  function automatic logic signed [PROD_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    fx_mul = a * b;
  endfunction

endpackage

/* hdl/vt44_front.sv */
// Front part: accepts items, holds the mode register and classifies items into jobs.
module vt44_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          operation,
  input  logic [vt44_pkg::IDX_W-1:0]    coeff_index,
  input  logic [vt44_pkg::DATA_W-1:0]   coeff_value,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_x,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_y,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_z,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_w,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  input  vt44_pkg::qstat_t              q_stat,
  output logic                          q_push,
  output vt44_pkg::job_t                q_job
);

  logic affine_mode;

  // The mode register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      affine_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      affine_mode <= cfg_data;
    end
  end

  // In affine mode w is replaced by one, so the translation column passes unchanged
  // through the multiply and the floor shift.
  always_comb begin
    q_job.op     = vt44_pkg::op_t'(operation);
    q_job.affine = affine_mode;
    q_job.index  = coeff_index;
    q_job.value  = coeff_value;
    q_job.vec[0] = vec_x;
    q_job.vec[1] = vec_y;
    q_job.vec[2] = vec_z;
    q_job.vec[3] = affine_mode ? vt44_pkg::FX_ONE : vec_w;
  end

  // An item enters the job queue whenever there is room.
  assign q_push = push && !q_stat.full;

endmodule

/* hdl/vt44_queue.sv */
// Short job queue between the front and the back parts.
module vt44_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vt44_pkg::job_t    job_in,
  input  logic              pop,
  output vt44_pkg::job_t    job_out,
  output vt44_pkg::qstat_t  stat
);

  vt44_pkg::job_t                  entries [vt44_pkg::QDEPTH];
  logic [vt44_pkg::QPTR_W-1:0]     wr_ptr;
  logic [vt44_pkg::QPTR_W-1:0]     rd_ptr;
  logic [vt44_pkg::QCNT_W-1:0]     count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  assign job_out    = entries[rd_ptr];
  assign stat.full  = (count == vt44_pkg::QCNT_W'(vt44_pkg::QDEPTH));
  assign stat.empty = (count == '0);

endmodule

/* hdl/vt44_back.sv */
// Back part: coefficient store, multiply and sum pipeline, and result buffer.
module vt44_back (
  input  logic                clk,
  input  logic                rst,
  input  vt44_pkg::qstat_t    q_stat,
  input  vt44_pkg::job_t      q_job,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output vt44_pkg::result_t   res
);

  localparam int N = vt44_pkg::VEC_N;

  logic [vt44_pkg::DATA_W-1:0]         coeff   [vt44_pkg::NUM_COEFF];
  logic signed [vt44_pkg::PROD_W-1:0]  prod    [vt44_pkg::NUM_COEFF];
  logic                                v1;
  logic                                aff1;
  logic                                credit_ok;
  logic                                is_load;
  logic signed [vt44_pkg::SUM_W-1:0]   sum     [N];
  logic [N-1:0]                        clip;
  vt44_pkg::result_t                   res_next;
  vt44_pkg::result_t                   obuf    [vt44_pkg::QDEPTH];
  logic [vt44_pkg::QPTR_W-1:0]         owr_ptr;
  logic [vt44_pkg::QPTR_W-1:0]         ord_ptr;
  logic [vt44_pkg::QCNT_W-1:0]         ocount;
  logic                                out_take;

  // A transform job is taken only when the result buffer has room for it and for
  // the one already in the multiply stage; a load job is always taken.
  assign is_load   = (q_job.op == vt44_pkg::OP_LOAD);
  assign credit_ok = (ocount + vt44_pkg::QCNT_W'(v1)) < vt44_pkg::QCNT_W'(vt44_pkg::QDEPTH);
  assign q_pop     = !q_stat.empty && (is_load || credit_ok);

  // Coefficient store, reset to the identity matrix; loads apply in item order.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < N; c++) begin
        for (int r = 0; r < N; r++) begin
          coeff[c*N + r] <= (c == r) ? vt44_pkg::FX_ONE : '0;
        end
      end
    end else if (q_pop && is_load) begin
      coeff[q_job.index] <= q_job.value;
    end
  end

  // Stage one: sixteen products, element c*4+r times component c.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= q_pop && !is_load;
    end
  end

  always_ff @(posedge clk) begin
    aff1 <= q_job.affine;
    for (int c = 0; c < N; c++) begin
      for (int r = 0; r < N; r++) begin
        prod[c*N + r] <= vt44_pkg::fx_mul(coeff[c*N + r], q_job.vec[c]);
      end
    end
  end

  // Stage two: floor shift, row sums and clipping to 32 bits.
  always_comb begin
    for (int r = 0; r < N; r++) begin
      sum[r] = '0;
      for (int c = 0; c < N; c++) begin
        sum[r] = sum[r] + {{2{prod[c*N + r][vt44_pkg::PROD_W-1]}},
                           prod[c*N + r][vt44_pkg::PROD_W-1:vt44_pkg::FRAC_BITS]};
      end
      clip[r] = !((&sum[r][vt44_pkg::SUM_W-1:vt44_pkg::DATA_W-1]) ||
                  (~|sum[r][vt44_pkg::SUM_W-1:vt44_pkg::DATA_W-1]));
      if (clip[r]) begin
        res_next.comp[r] = sum[r][vt44_pkg::SUM_W-1] ? vt44_pkg::SAT_MIN : vt44_pkg::SAT_MAX;
      end else begin
        res_next.comp[r] = sum[r][vt44_pkg::DATA_W-1:0];
      end
    end
    // In affine mode w is a fixed zero and never counts as clipped.
    if (aff1) begin
      res_next.comp[N-1] = '0;
      res_next.saturated = |clip[N-2:0];
    end else begin
      res_next.saturated = |clip;
    end
  end

  // Result buffer pointers and fill count.
  assign out_take = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (v1) begin
        owr_ptr <= owr_ptr + 1'b1;
      end
      if (out_take) begin
        ord_ptr <= ord_ptr + 1'b1;
      end
      case ({v1, out_take})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      obuf[owr_ptr] <= res_next;
    end
  end

  assign empty = (ocount == '0);
  assign res   = obuf[ord_ptr];

endmodule

/* hdl/vertex_transform_4x4_unit.sv */
// Top level of the 4x4 vertex transform unit: front, job queue and back.
//
//   Channel   Handshake            Moves
//   input     push / full          one load or transform item
//   result    empty / pop          one transformed vector with its clip flag
//   config    cfg_valid/cfg_ready  the affine mode bit
//
// One item is accepted per cycle while the job queue is not full. A transform item
// passes through the job queue and the product registers, waiting in the job queue
// while the result buffer has no room for it; it then waits in the result buffer.
// Reset clears the queues, the mode bit and loads the identity matrix. A stalled result
// side fills the four-entry result buffer, then the four-entry job queue, and
// only then raises full.
module vertex_transform_4x4_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation,
  input  logic [vt44_pkg::IDX_W-1:0]    coeff_index,
  input  logic [vt44_pkg::DATA_W-1:0]   coeff_value,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_x,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_y,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_z,
  input  logic [vt44_pkg::DATA_W-1:0]   vec_w,
  output logic                          empty,
  input  logic                          pop,
  output logic [vt44_pkg::DATA_W-1:0]   out_x,
  output logic [vt44_pkg::DATA_W-1:0]   out_y,
  output logic [vt44_pkg::DATA_W-1:0]   out_z,
  output logic [vt44_pkg::DATA_W-1:0]   out_w,
  output logic                          saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  vt44_pkg::qstat_t   q_stat;
  vt44_pkg::job_t     push_job;
  vt44_pkg::job_t     head_job;
  vt44_pkg::result_t  res;
  logic               q_push;
  logic               q_pop;

  // Accept and classify.
  vt44_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .operation   (operation),
    .coeff_index (coeff_index),
    .coeff_value (coeff_value),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .vec_z       (vec_z),
    .vec_w       (vec_w),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // Decouple the two parts.
  vt44_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (push_job),
    .pop     (q_pop),
    .job_out (head_job),
    .stat    (q_stat)
  );

  // Carry out loads and transforms.
  vt44_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_job  (head_job),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .res    (res)
  );

  // Result fields.
  assign full      = q_stat.full;
  assign out_x     = res.comp[0];
  assign out_y     = res.comp[1];
  assign out_z     = res.comp[2];
  assign out_w     = res.comp[3];
  assign saturated = res.saturated;

endmodule

/* hdl/vt44_checker.sv */
// Port-level checker of the 4x4 vertex transform unit and its bind statement.
module vt44_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [vt44_pkg::DATA_W-1:0]   out_x,
  input logic [vt44_pkg::DATA_W-1:0]   out_y,
  input logic [vt44_pkg::DATA_W-1:0]   out_z,
  input logic [vt44_pkg::DATA_W-1:0]   out_w,
  input logic                          saturated
);

  // The result buffer comes out of reset empty and the job queue not full.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // A clipped result has at least one component at a bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (!empty && saturated) |->
      (out_x == vt44_pkg::SAT_MAX || out_x == vt44_pkg::SAT_MIN ||
       out_y == vt44_pkg::SAT_MAX || out_y == vt44_pkg::SAT_MIN ||
       out_z == vt44_pkg::SAT_MAX || out_z == vt44_pkg::SAT_MIN ||
       out_w == vt44_pkg::SAT_MAX || out_w == vt44_pkg::SAT_MIN))
    else $error("saturated set with no component at a bound");

  // The input side fills up only through pushed items.
  a_full_by_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_x) && $stable(out_y) &&
                          $stable(out_z) && $stable(out_w) && $stable(saturated)))
    else $error("waiting result changed before it was taken");

endmodule

bind vertex_transform_4x4_unit vt44_checker u_vt44_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .out_w     (out_w),
  .saturated (saturated)
);

/* tb/sv/vertex_transform_4x4_unit_test.sv */
// Self-checking testbench for the 4x4 vertex transform unit with its own predictor.
module vertex_transform_4x4_unit_test;
  import vt44_pkg::*;

  // Cycles without any accepted item before the run is declared hung.
  localparam int HANG_LIMIT   = 4000;
  // Pipeline settling time for the unit and its queues.
  localparam int DRAIN_CYCLES = 16;
  localparam longint CLIP_HI  = longint'($signed(SAT_MAX));
  localparam longint CLIP_LO  = longint'($signed(SAT_MIN));

  typedef struct {
    op_t               op;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] vx, vy, vz, vw;
  } vt_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] x, y, z, w;
    logic              sat;
  } vt_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic              operation = OP_LOAD;
  logic [IDX_W-1:0]  coeff_index = '0;
  logic [DATA_W-1:0] coeff_value = '0;
  logic [DATA_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0, vec_w = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [DATA_W-1:0] out_x, out_y, out_z, out_w;
  logic              saturated;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  vt_item_t   pending_items[$];
  vt_result_t expected_vectors[$];

  // Predictor state: a private copy of the coefficient store and the mode bit.
  logic signed [DATA_W-1:0] coef_store [NUM_COEFF];
  logic                     affine_q;
  logic                     no_gaps = 1'b0;
  int                       err_count = 0;
  int                       n_loads = 0, n_xforms = 0, n_clipped = 0, n_checked = 0;
  int                       hang_cycles = 0;

  vertex_transform_4x4_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .coeff_index(coeff_index), .coeff_value(coeff_value),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .vec_w(vec_w),
    .empty(empty), .pop(pop),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Matrix-vector product with floor-truncated products and clipped sums.
  function automatic vt_result_t transform_vec(input logic [DATA_W-1:0] vx, vy, vz, vw);
    logic signed [DATA_W-1:0] vin [VEC_N];
    logic [DATA_W-1:0]        comp [VEC_N];
    longint                   acc;
    vt_result_t               res;
    vin[0] = vx;
    vin[1] = vy;
    vin[2] = vz;
    vin[3] = vw;
    res.sat = 1'b0;
    for (int r = 0; r < VEC_N; r++) begin
      acc = 0;
      if (affine_q && r == VEC_N - 1) begin
        // The w row is a fixed zero in affine mode and never clips.
        comp[r] = '0;
      end else begin
        for (int c = 0; c < VEC_N; c++) begin
          if (affine_q && c == VEC_N - 1)
            acc += longint'(coef_store[c*VEC_N + r]);
          else
            acc += (longint'(coef_store[c*VEC_N + r]) * longint'(vin[c])) >>> FRAC_BITS;
        end
        if (acc > CLIP_HI) begin
          acc = CLIP_HI;
          res.sat = 1'b1;
        end else if (acc < CLIP_LO) begin
          acc = CLIP_LO;
          res.sat = 1'b1;
        end
        comp[r] = acc[DATA_W-1:0];
      end
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.w = comp[3];
    return res;
  endfunction

  // Random fixed-point value: mostly within +-span, sometimes extreme or fully random.
  function automatic logic [DATA_W-1:0] rand_fx(input int unsigned span);
    logic [DATA_W-1:0] mag;
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return '0;
          3: return '1;
          4: return FX_ONE;
          default: return -FX_ONE;
        endcase
      end
      default: begin
        mag = $urandom_range(0, span);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  task automatic add_load(input int idx, input logic [DATA_W-1:0] val);
    vt_item_t it;
    it.op = OP_LOAD;
    it.index = IDX_W'(idx);
    it.value = val;
    it.vx = $urandom();
    it.vy = $urandom();
    it.vz = $urandom();
    it.vw = $urandom();
    pending_items.push_back(it);
  endtask

  task automatic add_xform(input logic [DATA_W-1:0] x, y, z, w);
    vt_item_t it;
    it.op = OP_XFORM;
    it.index = IDX_W'($urandom());
    it.value = $urandom();
    it.vx = x;
    it.vy = y;
    it.vz = z;
    it.vw = w;
    pending_items.push_back(it);
  endtask

  // Batches of coefficient loads followed by vector streams, with stray loads mixed in.
  task automatic add_random_items(input int count);
    int queued;
    int n_coef;
    int n_vec;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < NUM_COEFF; i++) add_load(i, rand_fx(4 << FRAC_BITS));
        queued += NUM_COEFF;
      end else begin
        n_coef = $urandom_range(0, 6);
        for (int i = 0; i < n_coef; i++)
          add_load($urandom_range(0, NUM_COEFF - 1), rand_fx(4 << FRAC_BITS));
        queued += n_coef;
      end
      n_vec = $urandom_range(1, 24);
      for (int i = 0; i < n_vec; i++) begin
        if ($urandom_range(0, 9) == 0)
          add_load($urandom_range(0, NUM_COEFF - 1), rand_fx(4 << FRAC_BITS));
        else
          add_xform(rand_fx(1024 << FRAC_BITS), rand_fx(1024 << FRAC_BITS),
                    rand_fx(1024 << FRAC_BITS), rand_fx(1024 << FRAC_BITS));
      end
      queued += n_vec;
    end
  endtask

  // Wait until every item is accepted and every result has come back, then let loads settle.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || push || expected_vectors.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Item driver: presents the next pending item, idling at random unless gaps are off.
  always @(posedge clk) begin
    vt_item_t it;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (pending_items.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 33)) begin
        it = pending_items.pop_front();
        push        <= 1'b1;
        operation   <= it.op;
        coeff_index <= it.index;
        coeff_value <= it.value;
        vec_x       <= it.vx;
        vec_y       <= it.vy;
        vec_z       <= it.vz;
        vec_w       <= it.vw;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Predictor: tracks the mode and the coefficient store, expects one result per transform.
  always @(posedge clk) begin
    vt_result_t res;
    if (rst) begin
      for (int i = 0; i < NUM_COEFF; i++)
        coef_store[i] = (i % (VEC_N + 1) == 0) ? FX_ONE : '0;
      affine_q = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) affine_q = cfg_data;
      if (push && !full) begin
        if (operation == OP_LOAD) begin
          coef_store[coeff_index] = coeff_value;
          n_loads++;
        end else begin
          res = transform_vec(vec_x, vec_y, vec_z, vec_w);
          expected_vectors.push_back(res);
          n_xforms++;
          if (res.sat) n_clipped++;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                      input logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    vt_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_vectors.size() == 0) begin
          $error("result item with no expectation waiting: %h %h %h %h %b",
                 out_x, out_y, out_z, out_w, saturated);
          err_count++;
        end else begin
          want = expected_vectors.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_z", want.z, out_z);
          check_field("out_w", want.w, out_w);
          check_field("saturated", DATA_W'(want.sat), DATA_W'(saturated));
          n_checked++;
        end
      end
      pop <= no_gaps || $urandom_range(0, 99) >= 33;
    end
  end

  // Hang detector: counts cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // Test sequence: directed corner cases in both modes, then random phases.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // Identity matrix: extreme and unit vectors pass unchanged.
    add_xform(SAT_MAX, SAT_MIN, '0, '1);
    add_xform(32'd1, '1, FX_ONE, -FX_ONE);
    // Largest coefficients force positive and negative clipping.
    add_load(0, SAT_MAX);
    add_load(NUM_COEFF - 1, SAT_MIN);
    add_xform(SAT_MAX, '0, '0, '0);
    add_xform(SAT_MIN, '0, '0, '0);
    add_xform('0, '0, '0, SAT_MAX);
    // A tiny coefficient shows truncation toward minus infinity.
    add_load(0, 32'd1);
    add_xform('1, '0, '0, '0);
    add_xform(32'd1, '0, '0, '0);
    add_load(0, FX_ONE);
    add_load(NUM_COEFF - 1, FX_ONE);
    wait_idle();

    // Affine mode: translation added, input w ignored, output w zero.
    write_mode(1'b1);
    add_load(12, SAT_MAX);
    add_xform(FX_ONE, '0, '0, SAT_MIN);
    add_xform('0, '0, '0, $urandom());
    add_load(12, '0);
    add_load(3, SAT_MAX);
    add_load(7, SAT_MAX);
    add_load(NUM_COEFF - 1, SAT_MAX);
    add_xform(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    add_load(13, SAT_MIN);
    add_xform('0, -FX_ONE, '0, '0);
    add_random_items(340);
    wait_idle();

    write_mode(1'b0);
    add_random_items(360);
    wait_idle();

    // One phase runs back to back with no idling on either side.
    write_mode(1'b1);
    no_gaps = 1'b1;
    add_random_items(360);
    wait_idle();
    no_gaps = 1'b0;

    write_mode(1'b0);
    add_random_items(360);
    wait_idle();

    $display("Covered %0d coefficient loads and %0d transforms (%0d clipped), %0d results checked,",
             n_loads, n_xforms, n_clipped, n_checked);
    $display("across both transform modes with random and gap-free handshakes.");
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
